// ===== src/gbn_sw_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Shared types and constants for the sender window core: the event and result
// codes, the payload structs and the configuration register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_sw_pkg;

  // Default size of the modulo sequence space.
  localparam int SEQ_COUNT_DEF = 32;

  // Widths of the configuration registers.
  localparam int WIN_W   = 5;
  localparam int TOTAL_W = 16;
  localparam int POLL_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST   = WIN_W'(10);
  localparam logic [TOTAL_W-1:0] TOTAL_PACKETS_RST = TOTAL_W'(30);
  localparam logic [POLL_W-1:0]  TIMEOUT_POLLS_RST = POLL_W'(20);

  // Event codes carried by an input item.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SEND  = 2'd1,
    OP_ACK   = 2'd2,
    OP_POLL  = 2'd3
  } opcode_t;

  // Result codes.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_ACK_OK  = 3'd2,
    ACT_ACK_IGN = 3'd3,
    ACT_GO_BACK = 3'd4,
    ACT_DONE    = 3'd5
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_TOTAL_PACKETS = 2'd1,
    REG_TIMEOUT_POLLS = 2'd2
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] ack_byte;
  } gbn_in_t;

  // One result item.
  typedef struct packed {
    action_t     action;
    logic [5:0]  seq_byte;
    logic [15:0] packet_number;
    logic [4:0]  oldest_unacked_out;
    logic [4:0]  in_flight;
    logic [7:0]  idle_count_out;
  } gbn_out_t;

endpackage

`default_nettype wire

// ===== src/gbn_sender_window_core.sv =====
// Path: an item passes through the input register, then the result register.
// Throughput: one item per cycle while the result channel is not stalled;
//   the window update is done in a single pass.
// Reset: synchronous, active low; clears the window and the handshake state,
//   marks every sequence number free and loads the register defaults.
// ----------------------------------------------------------------------------
// Go-Back-N sender window core
// Tracks the send window over a modulo sequence space, issues packets on send
// opportunities, advances on cumulative acks and rewinds on idle timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_sender_window_core
  import gbn_sw_pkg::*;
#(
  parameter int SEQ_COUNT = SEQ_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire gbn_in_t               in_data,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gbn_out_t                   out_data,
  // Configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SEQ_W = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam logic [SEQ_W:0]   SEQ_CNT_X = (SEQ_W+1)'(SEQ_COUNT);
  localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_COUNT - 1);
  localparam int CMP_W = ((SEQ_W > WIN_W) ? SEQ_W : WIN_W) + 1;

  // Distance from 'from' up to 'to' around the sequence ring.
  function automatic logic [SEQ_W-1:0] ring_dist(input logic [SEQ_W-1:0] to,
                                                 input logic [SEQ_W-1:0] from);
    logic [SEQ_W:0] sum;
    sum = {1'b0, to} + SEQ_CNT_X - {1'b0, from};
    if (sum >= SEQ_CNT_X) begin
      sum = sum - SEQ_CNT_X;
    end
    return sum[SEQ_W-1:0];
  endfunction

  // Successor of a sequence number with wrap.
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
    return (v == SEQ_LAST) ? '0 : v + SEQ_W'(1);
  endfunction

  // Configuration registers
  logic [WIN_W-1:0]   window_size_r;
  logic [TOTAL_W-1:0] total_packets_r;
  logic [POLL_W-1:0]  timeout_polls_r;

  // Window state
  logic [SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]     oldest_r, oldest_nxt;
  logic [TOTAL_W-1:0]   issued_r, issued_nxt;
  logic [POLL_W-1:0]    idle_r, idle_nxt;
  logic [SEQ_COUNT-1:0] seq_free_r, seq_free_nxt;
  logic                 finished_r, finished_nxt;

  // Input register and result register
  logic     s1_valid_r;
  gbn_in_t  s1_item_r;
  logic     out_valid_r;
  gbn_out_t out_item_r;
  logic     s1_adv;

  // Working values for the current item
  logic [SEQ_W-1:0]     flight;
  logic [7:0]           ack_idx;
  logic                 ack_idx_ok;
  logic [SEQ_W-1:0]     ack_seq;
  logic [SEQ_W-1:0]     ack_dist;
  logic [SEQ_COUNT-1:0] ack_mask;
  logic [SEQ_COUNT-1:0] flight_mask;
  logic [POLL_W:0]      polls;
  logic                 send_ok;
  action_t              act;
  logic                 sent;
  gbn_out_t             res;

  // Handshake: the item moves on whenever the result register is free or drains.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_SIZE_RST;
      total_packets_r <= TOTAL_PACKETS_RST;
      timeout_polls_r <= TIMEOUT_POLLS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_SIZE:   window_size_r   <= cfg_data[WIN_W-1:0];
        REG_TOTAL_PACKETS: total_packets_r <= cfg_data[TOTAL_W-1:0];
        REG_TIMEOUT_POLLS: timeout_polls_r <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring positions of the ack and the range masks it and a timeout free.
  always_comb begin
    flight     = ring_dist(next_seq_r, oldest_r);
    ack_idx    = s1_item_r.ack_byte - 8'd1;
    ack_idx_ok = ({1'b0, ack_idx} < 9'(SEQ_COUNT));
    ack_seq    = SEQ_W'(ack_idx);
    ack_dist   = ring_dist(ack_seq, oldest_r);
    for (int i = 0; i < SEQ_COUNT; i++) begin
      ack_mask[i]    = (ring_dist(SEQ_W'(i), oldest_r) <= ack_dist);
      flight_mask[i] = (ring_dist(SEQ_W'(i), oldest_r) < flight);
    end
    polls   = {1'b0, idle_r} + (POLL_W+1)'(1);
    send_ok = (CMP_W'(flight) < CMP_W'(window_size_r)) &&
              (flight != SEQ_LAST) && seq_free_r[next_seq_r] &&
              (issued_r < total_packets_r);
  end

  // Window update for the event held in the input register.
  always_comb begin
    next_seq_nxt = next_seq_r;
    oldest_nxt   = oldest_r;
    issued_nxt   = issued_r;
    idle_nxt     = idle_r;
    seq_free_nxt = seq_free_r;
    finished_nxt = finished_r;
    act          = ACT_NONE;
    sent         = 1'b0;
    case (s1_item_r.opcode)
      OP_START: begin
        next_seq_nxt = '0;
        oldest_nxt   = '0;
        issued_nxt   = '0;
        idle_nxt     = '0;
        seq_free_nxt = '1;
        finished_nxt = 1'b0;
      end
      OP_SEND: begin
        if (!finished_r && send_ok) begin
          act                      = ACT_SEND;
          sent                     = 1'b1;
          seq_free_nxt[next_seq_r] = 1'b0;
          next_seq_nxt             = seq_inc(next_seq_r);
          issued_nxt               = issued_r + TOTAL_W'(1);
        end
      end
      OP_ACK: begin
        if (!finished_r) begin
          if (ack_idx_ok && (ack_dist < flight)) begin
            seq_free_nxt = seq_free_r | ack_mask;
            oldest_nxt   = seq_inc(ack_seq);
            act          = ACT_ACK_OK;
          end else begin
            act = ACT_ACK_IGN;
          end
          idle_nxt = '0;
          if ((oldest_nxt == next_seq_r) && (issued_r == total_packets_r)) begin
            finished_nxt = 1'b1;
            act          = ACT_DONE;
          end
        end
      end
      OP_POLL: begin
        if (!finished_r) begin
          if (polls > {1'b0, timeout_polls_r}) begin
            seq_free_nxt = seq_free_r | flight_mask;
            issued_nxt   = issued_r - TOTAL_W'(flight);
            next_seq_nxt = oldest_r;
            idle_nxt     = '0;
            act          = ACT_GO_BACK;
          end else begin
            idle_nxt = polls[POLL_W-1:0];
          end
        end
      end
      default: ;
    endcase

    // Result item built from the state after the step; a send reports its own seq and packet.
    res.action             = act;
    res.seq_byte           = sent ? (6'(next_seq_r) + 6'd1) : 6'd0;
    res.packet_number      = sent ? issued_r : issued_nxt;
    res.oldest_unacked_out = 5'(oldest_nxt);
    res.in_flight          = 5'(ring_dist(next_seq_nxt, oldest_nxt));
    res.idle_count_out     = idle_nxt;
  end

  // Window state registers, updated as each item passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r <= '0;
      oldest_r   <= '0;
      issued_r   <= '0;
      idle_r     <= '0;
      seq_free_r <= '1;
      finished_r <= 1'b0;
    end else if (s1_adv) begin
      next_seq_r <= next_seq_nxt;
      oldest_r   <= oldest_nxt;
      issued_r   <= issued_nxt;
      idle_r     <= idle_nxt;
      seq_free_r <= seq_free_nxt;
      finished_r <= finished_nxt;
    end
  end

  // Input register: takes a transfer whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // Result register: holds a result until the downstream transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== bench/gbn_sw_checker.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender window checker
// Watches the input, result and configuration channels of the sender window
// core. Each input transfer is run through a local model of the window, and
// the result it should give is queued. Each result transfer is compared field
// by field with the oldest queued result. The failure count, the number of
// results still awaited and a few window hints are handed to the bench top.
// ----------------------------------------------------------------------------

module gbn_sw_checker
  import gbn_sw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  gbn_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  gbn_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output logic [4:0] await_seq,
  output logic [4:0] in_flight_cnt,
  output logic       xfer_done
);

  localparam int SEQ = SEQ_COUNT_DEF;

  // Register copies.
  logic [WIN_W-1:0]   win_reg;
  logic [TOTAL_W-1:0] total_reg;
  logic [POLL_W-1:0]  tmo_reg;

  // Window state of the model.
  logic [4:0]     next_seq;
  logic [4:0]     oldest;
  logic [15:0]    issued;
  logic [7:0]     idle_polls;
  logic [SEQ-1:0] seq_free;
  logic           done;

  gbn_out_t awaited_results[$];
  gbn_out_t want;
  gbn_out_t got;
  int       errors = 0;

  function automatic int ring_dist(input int to, input int from);
    return (to + SEQ - from) % SEQ;
  endfunction

  function void release_seqs(input int first, input int count);
    int i;
    for (i = 0; i < count; i++) seq_free[(first + i) % SEQ] = 1'b1;
  endfunction

  function void clear_transfer();
    next_seq   = '0;
    oldest     = '0;
    issued     = '0;
    idle_polls = '0;
    done       = 1'b0;
    seq_free   = '1;
  endfunction

  // Applies one event to the model window and returns the result it gives.
  function void predict_window_step(input gbn_in_t ev, output gbn_out_t res);
    int          flight;
    int          lim;
    int          idx;
    int          polls;
    action_t     act;
    logic [5:0]  sbyte;
    logic [15:0] pkt;
    logic        sent;
    flight = ring_dist(next_seq, oldest);
    lim    = (int'(win_reg) > SEQ - 1) ? SEQ - 1 : int'(win_reg);
    act    = ACT_NONE;
    sbyte  = '0;
    pkt    = '0;
    sent   = 1'b0;
    case (ev.opcode)
      OP_START: clear_transfer();
      OP_SEND: begin
        if (!done && flight < lim && seq_free[next_seq] && issued < total_reg) begin
          act   = ACT_SEND;
          sent  = 1'b1;
          sbyte = 6'(int'(next_seq) + 1);
          pkt   = issued;
          seq_free[next_seq] = 1'b0;
          next_seq = 5'((int'(next_seq) + 1) % SEQ);
          issued   = issued + 16'd1;
        end
      end
      OP_ACK: begin
        if (!done) begin
          // The wire byte carries the sequence number plus one.
          idx = (int'(ev.ack_byte) + 255) % 256;
          if (idx < SEQ && ring_dist(idx, oldest) < flight) begin
            release_seqs(oldest, ring_dist(idx, oldest) + 1);
            oldest = 5'((idx + 1) % SEQ);
            act    = ACT_ACK_OK;
          end else begin
            act = ACT_ACK_IGN;
          end
          idle_polls = '0;
          if (oldest == next_seq && issued == total_reg) begin
            done = 1'b1;
            act  = ACT_DONE;
          end
        end
      end
      OP_POLL: begin
        if (!done) begin
          polls = int'(idle_polls) + 1;
          // Timeout rewinds by what is actually in flight.
          if (polls > int'(tmo_reg)) begin
            release_seqs(oldest, flight);
            issued     = issued - 16'(flight);
            next_seq   = oldest;
            idle_polls = '0;
            act        = ACT_GO_BACK;
          end else begin
            idle_polls = 8'(polls);
          end
        end
      end
      default: ;
    endcase
    if (!sent) pkt = issued;
    res.action             = act;
    res.seq_byte           = sbyte;
    res.packet_number      = pkt;
    res.oldest_unacked_out = oldest;
    res.in_flight          = 5'(ring_dist(next_seq, oldest));
    res.idle_count_out     = idle_polls;
  endfunction

  function void check_field(input string name, input logic [15:0] exp_v,
                            input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Results are checked before the transfer of the same edge is predicted:
  // a result never belongs to an input taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      win_reg   = WINDOW_SIZE_RST;
      total_reg = TOTAL_PACKETS_RST;
      tmo_reg   = TIMEOUT_POLLS_RST;
      clear_transfer();
      awaited_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        got = out_data;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected: expected none, actual %p",
                   $time, got);
        end else begin
          want = awaited_results.pop_front();
          check_field("action", 16'(want.action), 16'(got.action));
          check_field("seq_byte", 16'(want.seq_byte), 16'(got.seq_byte));
          check_field("packet_number", want.packet_number, got.packet_number);
          check_field("oldest_unacked_out", 16'(want.oldest_unacked_out),
                      16'(got.oldest_unacked_out));
          check_field("in_flight", 16'(want.in_flight), 16'(got.in_flight));
          check_field("idle_count_out", 16'(want.idle_count_out),
                      16'(got.idle_count_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_SIZE:   win_reg   = cfg_data[WIN_W-1:0];
          REG_TOTAL_PACKETS: total_reg = cfg_data[TOTAL_W-1:0];
          REG_TIMEOUT_POLLS: tmo_reg   = cfg_data[POLL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_window_step(in_data, want);
        awaited_results.push_back(want);
      end
    end
    // Values seen by the bench top are updated after the edge.
    fail_count    <= errors;
    pending       <= awaited_results.size();
    await_seq     <= oldest;
    in_flight_cnt <= 5'(ring_dist(next_seq, oldest));
    xfer_done     <= done;
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender window bench
// Drives the sender window core with a short directed sequence and then with
// random transfers of start, send, ack and poll events under several register
// settings and idling patterns. The checker beside the core predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb;
  import gbn_sw_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  gbn_in_t               in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  gbn_out_t              out_data;
  logic                  cfg_ready;

  int         fail_count;
  int         pending;
  logic [4:0] await_seq;
  logic [4:0] in_flight_cnt;
  logic       xfer_done;

  int send_gap_pct   = 19;
  int recv_stall_pct = 45;
  int quiet_cycles   = 0;

  always #5 clk = ~clk;

  gbn_sender_window_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gbn_sw_checker window_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .await_seq     (await_seq),
    .in_flight_cnt (in_flight_cnt),
    .xfer_done     (xfer_done)
  );

  // Receiver stalls at random.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One event transfer, after random sender gaps. Valid is left high.
  task drive_event(input opcode_t op, input logic [7:0] ack_b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, ack_byte: ack_b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Hold the sender off until every awaited result has come.
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Unused upper data bits are filled at random; the core keeps the low ones.
  task set_window(input int win, input int total, input int polls);
    drain_results();
    write_reg(REG_WINDOW_SIZE, {11'($urandom), 5'(win)});
    write_reg(REG_TOTAL_PACKETS, 16'(total));
    write_reg(REG_TIMEOUT_POLLS, {8'($urandom), 8'(polls)});
    cfg_valid <= 1'b0;
  endtask

  // One random step of a transfer: mostly sends and in-window acks, with
  // bursts of polls, stray acks and the odd restart.
  task random_event(output int count);
    logic [7:0] ack_b;
    int         r;
    int         k;
    int         burst;
    ack_b = 8'($urandom);
    r     = $urandom_range(99);
    count = 1;
    if (r < 2 || (xfer_done && r < 60)) begin
      drive_event(OP_START, ack_b);
    end else if (r < 47) begin
      drive_event(OP_SEND, ack_b);
    end else if (r < 72) begin
      if (in_flight_cnt != 0) begin
        k     = $urandom_range(int'(in_flight_cnt) - 1);
        ack_b = 8'((int'(await_seq) + k) % SEQ_COUNT_DEF + 1);
      end
      drive_event(OP_ACK, ack_b);
    end else if (r < 78) begin
      drive_event(OP_ACK, ack_b);
    end else begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(18, 30) : $urandom_range(1, 4);
      for (k = 0; k < burst; k++) drive_event(OP_POLL, 8'($urandom));
      count = burst;
    end
  endtask

  task run_segment(input int win, input int total, input int polls, input int n_items);
    int sent_items;
    int step_items;
    logic held;
    sent_items = 0;
    held       = 1'b0;
    set_window(win, total, polls);
    while (sent_items < n_items) begin
      random_event(step_items);
      sent_items += step_items;
      if ((!held && sent_items >= n_items / 2) || $urandom_range(199) == 0) begin
        held = 1'b1;
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a narrow window with a short transfer and a quick timeout.
    set_window(3, 4, 1);
    drive_event(OP_SEND, 8'h00);    // the core may send straight after reset
    drive_event(OP_START, 8'hFF);
    drive_event(OP_SEND, 8'h00);
    drive_event(OP_SEND, 8'hAA);
    drive_event(OP_SEND, 8'h55);
    drive_event(OP_SEND, 8'h00);    // window full
    drive_event(OP_ACK, 8'd0);      // wire byte zero, ignored
    drive_event(OP_ACK, 8'd255);    // far outside the sequence space
    drive_event(OP_ACK, 8'd40);
    drive_event(OP_ACK, 8'd2);      // cumulative ack of the first two
    drive_event(OP_POLL, 8'h00);
    drive_event(OP_POLL, 8'h00);    // timeout, go back to the oldest
    drive_event(OP_SEND, 8'h00);
    drive_event(OP_SEND, 8'h00);
    drive_event(OP_SEND, 8'h00);    // nothing left to issue
    drive_event(OP_ACK, 8'd4);      // last ack finishes the transfer
    drive_event(OP_ACK, 8'd4);
    drive_event(OP_SEND, 8'h00);
    drive_event(OP_POLL, 8'h00);
    drive_event(OP_START, 8'h00);
    drive_event(OP_ACK, 8'd1);      // nothing in flight, ignored

    // Sender idles lightly, receiver heavily.
    run_segment(31, 40, 3, 300);
    run_segment(1, 12, 255, 250);

    // Sender idles heavily, receiver lightly.
    send_gap_pct   = 45;
    recv_stall_pct = 19;
    run_segment(0, 0, 0, 60);
    run_segment(17, 65535, 0, 250);
    run_segment(6, 25, 8, 250);

    // Neither side idles.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_segment(31, 100, 20, 300);
    run_segment(2, 7, 1, 300);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gbn_sw_pkg.sv
src/gbn_sender_window_core.sv
bench/gbn_sw_checker.sv
bench/tb.sv
